### sv/gwm_pkg.sv
package gwm_pkg;

  // Pattern storage and position set sizes
  localparam int PATTERN_MAX = 16;
  localparam int STORE_MAX   = 16;
  localparam int USE_MAX     = (PATTERN_MAX < STORE_MAX) ? PATTERN_MAX : STORE_MAX;
  localparam int POS_W       = USE_MAX + 1;
  localparam int LEN_W       = $clog2(USE_MAX + 1);
  localparam int PLEN_W      = 5;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Register map: index into the register list, byte address is 8*index
  localparam int REG_IDX_W = 2;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CHARS_LOW  = 2'd0,
    REG_CHARS_HIGH = 2'd1,
    REG_LENGTH     = 2'd2,
    REG_CASE_SENS  = 2'd3
  } reg_idx_t;

  // Item kinds carried on tuser
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Fold ASCII upper case to lower case unless exact compare is asked for
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### sv/glob_wildcard_matcher.sv
// Glob matcher for a byte stream. Load the pattern (up to 16 bytes, '*' any
// run, '?' any one byte, other bytes literal) and its length over APB, then
// stream the text one byte per transfer with tuser = 0 and close each text
// with a transfer that has tuser = 1; that transfer returns one result whose
// tdata bit 0 is 1 when the whole text matched the whole pattern. Text bytes
// return nothing. Every input transfer is held in the input register, and an
// end-of-text transfer then goes on to the result register, so the block takes
// one transfer per clock except while an end-of-text item waits in the input
// register on a held result. The rate is set by the update of the active-position
// set, a 17-bit vector with bit i set while pattern position i is reachable. A
// pattern length above 16 acts as 16. Write registers only while the stream is
// idle; a '*' in the text is an ordinary byte.
module glob_wildcard_matcher (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tuser,   // [0] action
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] matched, [7:1] zero
);
  import gwm_pkg::*;

  // Configuration registers
  logic [63:0]       chars_low;
  logic [63:0]       chars_high;
  logic [PLEN_W-1:0] pattern_length;
  logic              exact_cmp;

  // Input register
  logic              in_valid;
  logic              in_action;
  logic [7:0]        in_char;

  // Match state
  logic [POS_W-1:0]  active;
  logic [POS_W-1:0]  active_next;

  // Result register
  logic              out_valid;
  logic              out_matched;

  logic              cfg_write;
  reg_idx_t          cfg_idx;
  logic              in_adv;
  logic [LEN_W-1:0]  len;
  logic [7:0]        pat     [USE_MAX];
  logic [USE_MAX-1:0] star_ok;
  logic [POS_W-1:0]  closed;
  logic [7:0]        text_c;

  // ---------------------------------------------------------------------
  // APB: a write lands on the access cycle; reads return the register
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low      <= '0;
      chars_high     <= '0;
      pattern_length <= '0;
      exact_cmp      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_CHARS_LOW:  chars_low      <= pwdata;
        REG_CHARS_HIGH: chars_high     <= pwdata;
        REG_LENGTH:     pattern_length <= pwdata[PLEN_W-1:0];
        REG_CASE_SENS:  exact_cmp      <= pwdata[0];
        default:        chars_low      <= chars_low;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CHARS_LOW:  prdata = chars_low;
      REG_CHARS_HIGH: prdata = chars_high;
      REG_LENGTH:     prdata = {{(64-PLEN_W){1'b0}}, pattern_length};
      REG_CASE_SENS:  prdata = {63'd0, exact_cmp};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control. The input register drains whenever its item makes
  // no result or the result register is free or being taken.
  // ---------------------------------------------------------------------
  assign in_adv        = in_valid &
                         ((in_action == ACT_TEXT) | ~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_char   <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------
  // Pattern view: saturate the length, slice bytes, mark usable stars
  // ---------------------------------------------------------------------
  assign len = (pattern_length > PLEN_W'(USE_MAX)) ? LEN_W'(USE_MAX)
                                                   : LEN_W'(pattern_length);

  always_comb begin
    for (int i = 0; i < USE_MAX; i++) begin
      if (i < 8) begin
        pat[i] = chars_low[8*(i%8) +: 8];
      end else begin
        pat[i] = chars_high[8*(i%8) +: 8];
      end
      star_ok[i] = (pat[i] == STAR_BYTE) && (LEN_W'(i) < len);
    end
  end

  // Star closure, flat form: position j is reached when some active
  // position i <= j is followed by stars all the way up to j.
  always_comb begin
    logic term;
    for (int j = 0; j < POS_W; j++) begin
      closed[j] = 1'b0;
      for (int i = 0; i <= j; i++) begin
        term = active[i];
        for (int k = i; k < j; k++) begin
          term = term & star_ok[k];
        end
        closed[j] = closed[j] | term;
      end
    end
  end

  // Advance the set by one text byte
  assign text_c = fold_char(in_char, exact_cmp);

  always_comb begin
    active_next = '0;
    for (int i = 0; i < USE_MAX; i++) begin
      if (closed[i] && (LEN_W'(i) < len)) begin
        if (pat[i] == STAR_BYTE) begin
          active_next[i] = 1'b1;
        end else if (pat[i] == ANY_BYTE ||
                     fold_char(pat[i], exact_cmp) == text_c) begin
          active_next[i+1] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= POS_W'(1);
    end else if (in_adv) begin
      if (in_action == ACT_END) begin
        active <= POS_W'(1);
      end else begin
        active <= active_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: load on end of text, drop once taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_adv && in_action == ACT_END) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_action == ACT_END) begin
      out_matched <= closed[len];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_matched};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_end_loads_result: assert property (@(posedge clk) disable iff (rst)
    in_adv && in_action == ACT_END |=> out_valid && active == POS_W'(1))
    else $error("end of text did not load a result and restart the set");

  a_text_no_result: assert property (@(posedge clk) disable iff (rst)
    in_adv && in_action == ACT_TEXT && out_valid && m_axis_tready |=> !out_valid)
    else $error("text byte produced a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && in_action == ACT_END && out_valid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_reset_set: assert property (@(posedge clk)
    rst |=> active == POS_W'(1) && !out_valid && !in_valid)
    else $error("reset did not restore the start state");

endmodule

### verif/gwm_checker.sv
module gwm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tuser,   // [0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [0] matched, [7:1] zero
  output int unsigned outstanding,
  output int unsigned mismatches
);
  import gwm_pkg::*;

  logic [63:0]       chars_lo;
  logic [63:0]       chars_hi;
  logic [PLEN_W-1:0] pat_len;
  logic              exact;
  logic [POS_W-1:0]  live;
  logic [POS_W-1:0]  reach;
  logic [POS_W-1:0]  nxt;
  logic [7:0]        c;
  logic [7:0]        p;
  logic [7:0]        want;
  logic              match_q[$];
  int                n;
  int                i;
  int unsigned       errs;

  function automatic logic [7:0] pat_at(input int k);
    if (k < 8) return chars_lo[8*k +: 8];
    return chars_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (!exact && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  function automatic int eff_len();
    return (int'(pat_len) > USE_MAX) ? USE_MAX : int'(pat_len);
  endfunction

  // an active star position also opens the one after it
  function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] s, input int len);
    int k;
    for (k = 0; k < len; k++) begin
      if (s[k] && pat_at(k) == STAR_BYTE) s[k+1] = 1'b1;
    end
    return s;
  endfunction

  task automatic flag(input string what, input logic [7:0] exp_v, input logic [7:0] got_v);
    errs++;
    if (errs <= 10) begin
      $display("mismatch at %0t (%s): expected %02h, got %02h", $time, what, exp_v, got_v);
    end
  endtask

  initial begin
    errs = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      chars_lo = '0;
      chars_hi = '0;
      pat_len  = '0;
      exact    = 1'b1;
      live     = POS_W'(1);
      match_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:3]))
          REG_CHARS_LOW:  chars_lo = pwdata;
          REG_CHARS_HIGH: chars_hi = pwdata;
          REG_LENGTH:     pat_len  = pwdata[PLEN_W-1:0];
          REG_CASE_SENS:  exact    = pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n = eff_len();
        reach = close_stars(live, n);
        if (s_axis_tuser == ACT_END) begin
          match_q = {match_q, reach[n]};
          live = POS_W'(1);
        end else begin
          c = fold_case(s_axis_tdata);
          nxt = '0;
          for (i = 0; i < n; i++) begin
            if (reach[i]) begin
              p = pat_at(i);
              if (p == STAR_BYTE) nxt[i] = 1'b1;
              else if (p == ANY_BYTE || fold_case(p) == c) nxt[i+1] = 1'b1;
            end
          end
          live = nxt;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_q.size() == 0) begin
          flag("result with no end of text waiting", 8'h00, m_axis_tdata);
        end else begin
          want = {7'b0, match_q.pop_front()};
          if (m_axis_tdata !== want) flag("matched", want, m_axis_tdata);
        end
      end
    end
    outstanding <= match_q.size();
    mismatches  <= errs;
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import gwm_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] text_char
  logic        s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] matched, [7:1] zero
  int unsigned outstanding;
  int unsigned mismatches;

  // Pattern as last loaded, used to shape texts that get deep into the pattern
  logic [7:0]  cur_pat [16];
  int          cur_len;
  logic        cur_exact;
  logic [7:0]  text_buf[$];
  logic        steady;     // no idling on either side while set
  int          sent;

  glob_wildcard_matcher dut (.*);
  gwm_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: the slowest correct run stays far below this
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Text bytes lean on letters, stars and zero so literals hit often
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 5);
    if (r < 3) return (8'h61 + 8'($urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    if (r == 3) return 8'($urandom_range(0, 255));
    if (r == 4) return STAR_BYTE;
    return 8'h00;
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return STAR_BYTE;
    if (r == 2) return ANY_BYTE;
    if (r == 3) return 8'h00;
    if (r == 9) return 8'($urandom_range(0, 255));
    return (8'h61 + 8'($urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  // Present one item; keep tvalid high when the next one follows with no gap
  task automatic send_item(input logic act, input logic [7:0] ch);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // End of text: the byte lane is don't-care, so fill it with noise
  task automatic close_text();
    send_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_item(ACT_TEXT, text_buf[i]);
    close_text();
  endtask

  // Drop the stream, drain every expected result, then let the pipe settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the write when pready is seen
  task automatic apb_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic cs);
    int i;
    wait_idle();
    for (i = 0; i < 8; i++) begin
      cur_pat[i]   = lo[8*i +: 8];
      cur_pat[i+8] = hi[8*i +: 8];
    end
    cur_len   = int'(len);
    cur_exact = cs;
    apb_write(REG_CHARS_LOW, lo);
    apb_write(REG_CHARS_HIGH, hi);
    apb_write(REG_LENGTH, {59'b0, len});
    apb_write(REG_CASE_SENS, {63'b0, cs});
  endtask

  // Build a text that follows the pattern, then maybe break it; some texts are pure noise
  task automatic fill_text();
    int n;
    int i;
    int pos;
    logic [7:0] p;
    text_buf.delete();
    n = (cur_len > USE_MAX) ? USE_MAX : cur_len;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 10)) text_buf = {text_buf, text_char()};
    end else begin
      for (i = 0; i < n; i++) begin
        p = cur_pat[i];
        if (p == STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) text_buf = {text_buf, text_char()};
        end else if (p == ANY_BYTE) begin
          text_buf = {text_buf, 8'($urandom_range(0, 255))};
        end else if (!cur_exact && (p | 8'h20) >= 8'h61 && (p | 8'h20) <= 8'h7A
                     && $urandom_range(0, 1) == 1) begin
          text_buf = {text_buf, p ^ 8'h20};
        end else begin
          text_buf = {text_buf, p};
        end
      end
      // Break about one in four: swap, drop or add a byte
      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, text_buf.size());
        case ($urandom_range(0, 2))
          0: if (pos < text_buf.size()) text_buf[pos] = text_char();
          1: if (pos < text_buf.size()) text_buf.delete(pos);
          default: text_buf.insert(pos, text_char());
        endcase
      end
    end
  endtask

  // Result side: runs of ready broken by stalls of random length
  initial begin
    int ready_run;
    int stall_run;
    ready_run = 0;
    stall_run = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_run > 0) begin
        m_axis_tready <= 1'b0;
        stall_run--;
      end else begin
        m_axis_tready <= 1'b1;
        if (ready_run > 0) begin
          ready_run--;
        end else begin
          ready_run = $urandom_range(0, 9) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 6);
          stall_run = idle_cycles();
        end
      end
    end
  end

  initial begin
    int phase;
    int target;
    int i;
    logic [7:0] pb [16];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    clk = 1'b0;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_TEXT;
    steady = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: empty pattern, so only the empty text matches
    close_text();
    send_item(ACT_TEXT, 8'h00);
    close_text();

    // Folded literal, star against a text star, any-byte on 0xFF, zero byte as literal
    load_pattern({32'hFFFF_FFFF, 8'h00, ANY_BYTE, STAR_BYTE, 8'h41}, 64'h0, 5'd4, 1'b0);
    text_buf = '{8'h61, STAR_BYTE, 8'hFF, 8'h00};
    send_text();
    text_buf = '{8'h61, 8'h78};
    send_text();

    // Length far past the store saturates; high bytes all ones
    load_pattern({8{STAR_BYTE}}, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1);
    text_buf.delete();
    repeat (8) text_buf = {text_buf, 8'hFF};
    send_text();

    // All stars: an empty text must match
    load_pattern({8{STAR_BYTE}}, 64'h0, 5'd8, 1'b1);
    close_text();

    // Swap the pattern while a text is half way through; the active set carries over
    load_pattern({48'h0, 8'h62, 8'h61}, 64'h0, 5'd2, 1'b1);
    send_item(ACT_TEXT, 8'h61);
    wait_idle();
    apb_write(REG_CHARS_LOW, {48'h0, 8'h62, 8'h78});
    send_item(ACT_TEXT, 8'h62);
    close_text();

    // Random phases: fresh pattern and settings, then a batch of texts
    phase = 0;
    while (sent < 725) begin
      phase++;
      for (i = 0; i < 16; i++) pb[i] = pattern_char();
      for (i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pb[i];
        hi[8*i +: 8] = pb[i+8];
      end
      if (phase == 1) len = 5'd16;
      else if (phase == 2) len = 5'd0;
      else if ($urandom_range(0, 9) == 0) len = 5'($urandom_range(17, 31));
      else len = 5'($urandom_range(0, 12));
      load_pattern(lo, hi, len, 1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 4) == 0);
      target = sent + $urandom_range(30, 70);
      while (sent < target) begin
        fill_text();
        send_text();
      end
      steady = 1'b0;
    end

    // Drain, allow for the two-stage pipe, then give the verdict
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### glob_wildcard_matcher.f
sv/gwm_pkg.sv
sv/glob_wildcard_matcher.sv
verif/gwm_checker.sv
verif/tb_top.sv
